### hdl/mmrp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the M-Bus meter reply parser.
// No dependencies; every other file depends on this package.
package mmrp_pkg;

  // Frame geometry
  localparam int FRAME_BYTES = 62;
  localparam int BYTE_W      = 8;
  localparam int INDEX_W     = 6;
  localparam int COUNT_W     = 32;
  localparam int ENERGY_W    = 28;
  localparam int READING_W   = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int BCD_DIGITS  = 4;

  // Frame positions of interest
  localparam logic [INDEX_W-1:0] POS_FIRST    = 6'd0;
  localparam logic [INDEX_W-1:0] POS_LEN_A    = 6'd1;
  localparam logic [INDEX_W-1:0] POS_LEN_B    = 6'd2;
  localparam logic [INDEX_W-1:0] POS_HEADER   = 6'd3;
  localparam logic [INDEX_W-1:0] POS_SUM_LO   = 6'd4;
  localparam logic [INDEX_W-1:0] POS_ADDR     = 6'd5;
  localparam logic [INDEX_W-1:0] POS_STATUS   = 6'd16;
  localparam logic [INDEX_W-1:0] POS_TOTAL    = 6'd22;
  localparam logic [INDEX_W-1:0] POS_PARTIAL  = 6'd29;
  localparam logic [INDEX_W-1:0] POS_VOLTAGE  = 6'd38;
  localparam logic [INDEX_W-1:0] POS_CURRENT  = 6'd45;
  localparam logic [INDEX_W-1:0] POS_ACTIVE   = 6'd51;
  localparam logic [INDEX_W-1:0] POS_REACTIVE = 6'd58;
  localparam logic [INDEX_W-1:0] POS_SUM_HI   = 6'd59;
  localparam logic [INDEX_W-1:0] POS_CHECKSUM = 6'd60;
  localparam logic [INDEX_W-1:0] POS_LAST     = 6'd61;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP   = 2'd2;

  localparam logic [BYTE_W-1:0] START_RESET  = 8'd104;
  localparam logic [BYTE_W-1:0] LENGTH_RESET = 8'd56;
  localparam logic [BYTE_W-1:0] STOP_RESET   = 8'd22;

  // Weight of each BCD byte, least significant byte first
  localparam logic [ENERGY_W-1:0] BCD_WEIGHT [BCD_DIGITS] =
    '{28'd1, 28'd100, 28'd10000, 28'd1000000};

  typedef enum logic [1:0] {
    STATUS_PENDING = 2'd0,
    STATUS_DONE    = 2'd1,
    STATUS_WRONG   = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_char;
    logic [BYTE_W-1:0] length_char;
    logic [BYTE_W-1:0] stop_char;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    meter_address;
    logic [BYTE_W-1:0]    meter_status;
    logic [ENERGY_W-1:0]  total_energy;
    logic [ENERGY_W-1:0]  partial_energy;
    logic [READING_W-1:0] voltage;
    logic [READING_W-1:0] current;
    logic [READING_W-1:0] active_power;
    logic [READING_W-1:0] quadrature_power;
  } decoded_t;

  typedef struct packed {
    frame_status_t       frame_status;
    logic [COUNT_W-1:0]  message_count;
    decoded_t            rec;
  } result_t;

  // Convert one BCD byte (unchecked nibbles) and scale it by its digit-pair weight
  function automatic logic [ENERGY_W-1:0] bcd_scaled(input logic [BYTE_W-1:0] b,
                                                      input logic [1:0] k);
    logic [BYTE_W-1:0] pair;
    pair = ({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
    return ENERGY_W'(pair) * BCD_WEIGHT[k];
  endfunction

endpackage

### hdl/mmrp_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input byte, decoded result, register write.
// Depends on mmrp_pkg.
interface mmrp_item_if;
  logic                           valid;
  logic                           ready;
  logic [mmrp_pkg::BYTE_W-1:0]    rx_byte;
  logic [mmrp_pkg::INDEX_W-1:0]   byte_index;
  modport source (output valid, rx_byte, byte_index, input ready);
  modport sink   (input valid, rx_byte, byte_index, output ready);
endinterface

interface mmrp_result_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       frame_status;
  logic [mmrp_pkg::COUNT_W-1:0]     message_count;
  logic [mmrp_pkg::BYTE_W-1:0]      meter_address;
  logic [mmrp_pkg::BYTE_W-1:0]      meter_status;
  logic [mmrp_pkg::ENERGY_W-1:0]    total_energy;
  logic [mmrp_pkg::ENERGY_W-1:0]    partial_energy;
  logic [mmrp_pkg::READING_W-1:0]   voltage;
  logic [mmrp_pkg::READING_W-1:0]   current;
  logic [mmrp_pkg::READING_W-1:0]   active_power;
  logic [mmrp_pkg::READING_W-1:0]   quadrature_power;
  modport source (output valid, frame_status, message_count, meter_address, meter_status,
                  total_energy, partial_energy, voltage, current, active_power,
                  quadrature_power, input ready);
  modport sink   (input valid, frame_status, message_count, meter_address, meter_status,
                  total_energy, partial_energy, voltage, current, active_power,
                  quadrature_power, output ready);
endinterface

interface mmrp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mmrp_pkg::CFG_IDX_W-1:0]    index;
  logic [mmrp_pkg::BYTE_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/mmrp_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file: start, length and stop characters.
// Depends on mmrp_pkg and mmrp_cfg_if.
module mmrp_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  mmrp_cfg_if.sink        cfg,
  output mmrp_pkg::cfg_t  regs
);
  import mmrp_pkg::*;

  // Writes are always taken
  assign cfg.ready = 1'b1;

  // Decode the register index and store the word
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_char  <= START_RESET;
      regs.length_char <= LENGTH_RESET;
      regs.stop_char   <= STOP_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_START:  regs.start_char  <= cfg.data;
        CFG_LENGTH: regs.length_char <= cfg.data;
        CFG_STOP:   regs.stop_char   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

### hdl/mmrp_frame_core.sv
`timescale 1ns / 1ps
// Frame checker and field decoder: captures bytes at their fixed positions,
// keeps the checksum and counter, and forms one result per byte. Depends on mmrp_pkg.
module mmrp_frame_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fire,
  input  logic [mmrp_pkg::BYTE_W-1:0]     rx_byte,
  input  logic [mmrp_pkg::INDEX_W-1:0]    byte_index,
  input  mmrp_pkg::cfg_t                  regs,
  output mmrp_pkg::result_t               res
);
  import mmrp_pkg::*;

  // Captured frame bytes (held only at the positions that are read later)
  logic [BYTE_W-1:0]   hdr_start;
  logic [BYTE_W-1:0]   hdr_len_a;
  logic [BYTE_W-1:0]   hdr_len_b;
  logic [BYTE_W-1:0]   chk_byte;
  logic [BYTE_W-1:0]   addr_byte;
  logic [BYTE_W-1:0]   stat_byte;
  logic [ENERGY_W-1:0] tot_part [BCD_DIGITS];
  logic [ENERGY_W-1:0] par_part [BCD_DIGITS];
  logic [BYTE_W-1:0]   volt_lo, volt_hi, curr_lo, curr_hi;
  logic [BYTE_W-1:0]   act_lo, act_hi, react_lo, react_hi;

  // Frame state
  logic [BYTE_W-1:0]   running_sum, running_sum_next;
  logic [COUNT_W-1:0]  good_frames, good_frames_next;
  decoded_t            decoded, decoded_next;

  logic                in_range;
  logic                header_bad;
  logic                tail_ok;
  frame_status_t       status;
  logic [ENERGY_W-1:0] tot_sum, par_sum;

  assign in_range = byte_index < INDEX_W'(FRAME_BYTES);

  // Running checksum: clear at the first byte, add over the summed span
  always_comb begin
    running_sum_next = running_sum;
    if (in_range) begin
      if (byte_index == POS_FIRST) begin
        running_sum_next = '0;
      end else if (byte_index >= POS_SUM_LO && byte_index <= POS_SUM_HI) begin
        running_sum_next = running_sum + rx_byte;
      end
    end
  end

  // Header and tail checks
  assign header_bad = (hdr_start != regs.start_char) || (hdr_len_a != regs.length_char) ||
                      (hdr_len_b != regs.length_char) || (rx_byte != regs.start_char);
  assign tail_ok    = (running_sum == chk_byte) && (rx_byte == regs.stop_char);

  // Energy counters from the pre-scaled BCD bytes
  assign tot_sum = (tot_part[0] + tot_part[1]) + (tot_part[2] + tot_part[3]);
  assign par_sum = (par_part[0] + par_part[1]) + (par_part[2] + par_part[3]);

  // Status, counter and decoded record
  always_comb begin
    status           = STATUS_PENDING;
    good_frames_next = good_frames;
    decoded_next     = decoded;
    if (byte_index == POS_HEADER) begin
      if (header_bad) begin
        status = STATUS_WRONG;
      end
    end else if (byte_index == POS_LAST) begin
      if (!tail_ok) begin
        status = STATUS_WRONG;
      end else begin
        status                        = STATUS_DONE;
        good_frames_next              = good_frames + 1'b1;
        decoded_next.meter_address    = addr_byte;
        decoded_next.meter_status     = stat_byte;
        decoded_next.total_energy     = tot_sum;
        decoded_next.partial_energy   = par_sum;
        decoded_next.voltage          = {volt_hi, volt_lo};
        decoded_next.current          = {curr_hi, curr_lo};
        decoded_next.active_power     = {act_hi, act_lo};
        decoded_next.quadrature_power = {react_hi, react_lo};
      end
    end
  end

  // Result shows the state as left by this byte
  assign res.frame_status  = status;
  assign res.message_count = good_frames_next;
  assign res.rec           = decoded_next;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      good_frames <= '0;
      decoded     <= '0;
    end else if (fire) begin
      running_sum <= running_sum_next;
      good_frames <= good_frames_next;
      decoded     <= decoded_next;
    end
  end

  // Capture bytes at their fixed positions
  always_ff @(posedge clk) begin
    if (fire) begin
      if (byte_index == POS_FIRST)    hdr_start <= rx_byte;
      if (byte_index == POS_LEN_A)    hdr_len_a <= rx_byte;
      if (byte_index == POS_LEN_B)    hdr_len_b <= rx_byte;
      if (byte_index == POS_ADDR)     addr_byte <= rx_byte;
      if (byte_index == POS_STATUS)   stat_byte <= rx_byte;
      if (byte_index == POS_CHECKSUM) chk_byte  <= rx_byte;
      if (byte_index == POS_VOLTAGE)          volt_lo  <= rx_byte;
      if (byte_index == POS_VOLTAGE + 6'd1)   volt_hi  <= rx_byte;
      if (byte_index == POS_CURRENT)          curr_lo  <= rx_byte;
      if (byte_index == POS_CURRENT + 6'd1)   curr_hi  <= rx_byte;
      if (byte_index == POS_ACTIVE)           act_lo   <= rx_byte;
      if (byte_index == POS_ACTIVE + 6'd1)    act_hi   <= rx_byte;
      if (byte_index == POS_REACTIVE)         react_lo <= rx_byte;
      if (byte_index == POS_REACTIVE + 6'd1)  react_hi <= rx_byte;
      for (int k = 0; k < BCD_DIGITS; k++) begin
        if (byte_index == POS_TOTAL + INDEX_W'(k)) begin
          tot_part[k] <= bcd_scaled(rx_byte, 2'(k));
        end
        if (byte_index == POS_PARTIAL + INDEX_W'(k)) begin
          par_part[k] <= bcd_scaled(rx_byte, 2'(k));
        end
      end
    end
  end

endmodule

### hdl/mbus_meter_reply_parser.sv
`timescale 1ns / 1ps
// Top level of the M-Bus long-frame meter reply parser.
// Depends on mmrp_pkg, mmrp_ifs, mmrp_cfg_regs and mmrp_frame_core.
//
//   channel | dir | word
//   --------+-----+----------------------------------------------------------
//   cfg     | in  | index (0 start, 1 length, 2 stop), data
//   item    | in  | rx_byte, byte_index
//   result  | out | frame_status, message_count, meter_address, meter_status,
//           |     | total_energy, partial_energy, voltage, current,
//           |     | active_power, quadrature_power
//
// One byte per cycle sustained while result.ready holds.
// The input register feeds the checker/decoder, whose one result per byte
// lands in the output register; the four-term BCD add sets the longest path.
// A byte is taken while a result waits, until the input register also holds one.
// rst loads the start, length and stop reset values and clears the counter,
// checksum and decoded record to zero.
module mbus_meter_reply_parser (
  input  logic          clk,
  input  logic          rst,
  mmrp_cfg_if.sink      cfg,
  mmrp_item_if.sink     item,
  mmrp_result_if.source result
);
  import mmrp_pkg::*;

  cfg_t                regs;
  result_t             core_res;
  result_t             res_reg;
  logic                out_valid;
  logic                s1_valid;
  logic [BYTE_W-1:0]   s1_byte;
  logic [INDEX_W-1:0]  s1_index;
  logic                s1_adv;

  mmrp_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Advance the input register when the output register is free or drained
  assign s1_adv     = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_byte  <= item.rx_byte;
      s1_index <= item.byte_index;
    end
  end

  mmrp_frame_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (s1_adv),
    .rx_byte    (s1_byte),
    .byte_index (s1_index),
    .regs       (regs),
    .res        (core_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_reg <= core_res;
    end
  end

  assign result.valid            = out_valid;
  assign result.frame_status     = res_reg.frame_status;
  assign result.message_count    = res_reg.message_count;
  assign result.meter_address    = res_reg.rec.meter_address;
  assign result.meter_status     = res_reg.rec.meter_status;
  assign result.total_energy     = res_reg.rec.total_energy;
  assign result.partial_energy   = res_reg.rec.partial_energy;
  assign result.voltage          = res_reg.rec.voltage;
  assign result.current          = res_reg.rec.current;
  assign result.active_power     = res_reg.rec.active_power;
  assign result.quadrature_power = res_reg.rec.quadrature_power;

endmodule

### hdl/mmrp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the meter reply parser, bound to the top level.
// Depends on mmrp_pkg and mmrp_ifs.
module mmrp_checker (
  input logic           clk,
  input logic           rst,
  mmrp_item_if.sink     item,
  mmrp_result_if.source result
);
  import mmrp_pkg::*;

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

  // Status is one of the three codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.frame_status == STATUS_PENDING ||
                      result.frame_status == STATUS_DONE ||
                      result.frame_status == STATUS_WRONG))
    else $error("bad frame status code");

  // With no result waiting, a new byte is always taken
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> item.ready)
    else $error("input stalled with empty output");

  // A stalled result stays valid and keeps its status, count, total energy and quadrature power
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.frame_status) &&
      $stable(result.message_count) && $stable(result.total_energy) &&
      $stable(result.quadrature_power))
    else $error("stalled result changed");

endmodule

bind mbus_meter_reply_parser mmrp_checker u_mmrp_checker (
  .clk    (clk),
  .rst    (rst),
  .item   (item),
  .result (result)
);
